>>> rtl/bcs_pkg.sv
// shared types, character codes and bracket decode for the bracket content stripper
package bcs_pkg;

  // bracket characters
  localparam logic [7:0] CH_PAREN_OPEN   = 8'h28;  // (
  localparam logic [7:0] CH_PAREN_CLOSE  = 8'h29;  // )
  localparam logic [7:0] CH_BRACE_OPEN   = 8'h7B;  // {
  localparam logic [7:0] CH_BRACE_CLOSE  = 8'h7D;  // }
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;  // <
  localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;  // >

  // bracket kind as stored on the stack
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_BRACE  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_ANGLE  = 2'd3;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2
  } bclass_t;

  typedef struct packed {
    bclass_t cls;
    kind_t   kind;
  } bracket_t;

  // configuration register map
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam int unsigned NEST_LIMIT_W = 5;
  localparam logic [0:0]  REG_NEST_LIMIT = 1'b0;
  localparam logic [NEST_LIMIT_W-1:0] NEST_LIMIT_RESET = 5'd16;

  // one result as it leaves the core
  typedef struct packed {
    logic       kept;
    logic [7:0] out_byte;
    logic       end_of_string;
  } result_t;

  function automatic bracket_t classify(input logic [7:0] b);
    bracket_t r;
    r.cls  = CLS_OTHER;
    r.kind = KIND_PAREN;
    case (b)
      CH_PAREN_OPEN: begin
        r.cls  = CLS_OPEN;
        r.kind = KIND_PAREN;
      end
      CH_PAREN_CLOSE: begin
        r.cls  = CLS_CLOSE;
        r.kind = KIND_PAREN;
      end
      CH_BRACE_OPEN: begin
        r.cls  = CLS_OPEN;
        r.kind = KIND_BRACE;
      end
      CH_BRACE_CLOSE: begin
        r.cls  = CLS_CLOSE;
        r.kind = KIND_BRACE;
      end
      CH_SQUARE_OPEN: begin
        r.cls  = CLS_OPEN;
        r.kind = KIND_SQUARE;
      end
      CH_SQUARE_CLOSE: begin
        r.cls  = CLS_CLOSE;
        r.kind = KIND_SQUARE;
      end
      CH_ANGLE_OPEN: begin
        r.cls  = CLS_OPEN;
        r.kind = KIND_ANGLE;
      end
      CH_ANGLE_CLOSE: begin
        r.cls  = CLS_CLOSE;
        r.kind = KIND_ANGLE;
      end
      default: begin
        r.cls  = CLS_OTHER;
        r.kind = KIND_PAREN;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/bcs_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module bcs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bcs_regs.sv
// apb configuration register block holding the nesting limit
module bcs_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bcs_pkg::PADDR_W-1:0]          paddr,
  input  logic [bcs_pkg::PDATA_W-1:0]          pwdata,
  output logic [bcs_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready,
  output logic [bcs_pkg::NEST_LIMIT_W-1:0]     nest_limit
);

  logic hit;

  // register index is the word address, byte offset ignored
  assign hit    = (paddr[bcs_pkg::PADDR_W-1:2] == bcs_pkg::REG_NEST_LIMIT);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_limit <= bcs_pkg::NEST_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      nest_limit <= pwdata[bcs_pkg::NEST_LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = bcs_pkg::PDATA_W'(nest_limit);
    end
  end

endmodule

>>> rtl/bcs_core.sv
// per-byte filter step: bracket decode, depth counter and kind stack
module bcs_core #(
  parameter int unsigned STACK_DEPTH      = 16,
  parameter int unsigned DEPTH_COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [7:0]                        in_byte,
  input  logic                              last_of_string,
  input  logic [bcs_pkg::NEST_LIMIT_W-1:0]  nest_limit,
  output bcs_pkg::result_t                  result
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LW = (DEPTH_COUNT_BITS > SW) ? DEPTH_COUNT_BITS : SW;

  logic [DEPTH_COUNT_BITS-1:0] depth;
  logic [DEPTH_COUNT_BITS-1:0] depth_step;
  logic [DEPTH_COUNT_BITS-1:0] depth_next;
  logic [LW-1:0]               depth_ext;
  logic [LW-1:0]               limit_ext;
  logic [LW-1:0]               size_ext;
  logic [LW-1:0]               lim;
  bcs_pkg::bracket_t           br;
  bcs_pkg::kind_t              rd_kind;
  bcs_pkg::kind_t              top_kind;
  bcs_pkg::kind_t              byp_kind;
  logic                        byp_hit;
  logic                        push;
  logic                        keep;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;

  assign depth_ext = LW'(depth);
  assign limit_ext = LW'(nest_limit);
  assign size_ext  = LW'(STACK_DEPTH);
  assign lim       = (limit_ext < size_ext) ? limit_ext : size_ext;

  always_comb begin
    br         = bcs_pkg::classify(in_byte);
    top_kind   = byp_hit ? byp_kind : rd_kind;
    push       = 1'b0;
    keep       = 1'b0;
    depth_step = depth;
    case (br.cls)
      bcs_pkg::CLS_OPEN: begin
        push = (depth_ext < lim);
        if (!(&depth)) begin
          depth_step = depth + 1'b1;
        end
      end
      bcs_pkg::CLS_CLOSE: begin
        if (depth_ext > lim) begin
          depth_step = depth - 1'b1;
        end else if ((depth != '0) && (top_kind == br.kind)) begin
          depth_step = depth - 1'b1;
        end
      end
      default: begin
        keep = (depth == '0);
      end
    endcase
    if (last_of_string) begin
      depth_step = '0;
    end
  end

  assign depth_next = accept ? depth_step : depth;
  assign we         = accept && push;
  assign waddr      = AW'(depth);
  // always prefetch the entry that will be on top next cycle
  assign raddr      = AW'(depth_next - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      byp_hit <= 1'b0;
    end else begin
      depth   <= depth_next;
      byp_hit <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_kind <= br.kind;
  end

  bcs_ram #(
    .WIDTH ($bits(bcs_pkg::kind_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (br.kind),
    .raddr (raddr),
    .rdata (rd_kind)
  );

  assign result.kept          = keep;
  assign result.out_byte      = keep ? in_byte : 8'h00;
  assign result.end_of_string = last_of_string;

endmodule

>>> rtl/bracket_content_stripper.sv
// top level of the bracket content stripper: config port, filter core, result register
//
// bracket content stripper: takes a text one byte per request and marks each byte
// kept or dropped. every bracket of the kinds (), {}, [] and <> is dropped, and so is
// every byte nested inside brackets. opening brackets push their kind onto a kind
// stack of STACK_DEPTH entries while the depth is below the effective limit (the
// smaller of nest_limit and STACK_DEPTH); deeper they are only counted. a closing
// bracket pops on a kind match, always pops above the limit, and is ignored on a
// mismatch or at depth zero. the depth counter is DEPTH_COUNT_BITS wide and
// saturates. the byte flagged last_of_string is processed normally and then the
// depth returns to zero; stack contents stay. throughput is one byte per clock:
// each request is processed in the cycle it is accepted and its result is in the
// output register the next cycle. what sets that rate is the depth counter loop,
// closed through the stack ram whose registered read port always prefetches the
// entry that will be on top next cycle (a same-cycle push is forwarded). the
// input is ready whenever the output register is empty or being drained, so a
// result taken in the same cycle does not hold off the next request; a stalled
// result does. nest_limit sits at byte address
// 0 and may only be written while no request is in flight. entries of the stack
// are undefined until pushed; no clearing pass is needed after reset.
module bracket_content_stripper #(
  parameter int unsigned STACK_DEPTH      = 16,
  parameter int unsigned DEPTH_COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [bcs_pkg::PDATA_W-1:0]   pwdata,
  output logic [bcs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // byte requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          last_of_string,
  // filtered results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kept,
  output logic [7:0]                    out_byte,
  output logic                          end_of_string
);

  logic [bcs_pkg::NEST_LIMIT_W-1:0] nest_limit;
  logic                             accept;
  bcs_pkg::result_t                 result;

  // configuration register
  bcs_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .nest_limit (nest_limit)
  );

  // take a new request whenever the result register frees up this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // filter core: state update and result for the accepted byte
  bcs_core #(
    .STACK_DEPTH      (STACK_DEPTH),
    .DEPTH_COUNT_BITS (DEPTH_COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (in_byte),
    .last_of_string (last_of_string),
    .nest_limit     (nest_limit),
    .result         (result)
  );

  // result register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register, payload held until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      kept          <= result.kept;
      out_byte      <= result.out_byte;
      end_of_string <= result.end_of_string;
    end
  end

endmodule

>>> rtl/bcs_checker.sv
// port-level checker for the bracket content stripper and its bind
module bcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       last_of_string,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kept,
  input logic [7:0] out_byte,
  input logic       end_of_string
);

  logic in_acc;
  logic is_bracket;

  assign in_acc     = in_valid && in_ready && !rst;
  assign is_bracket = (in_byte == bcs_pkg::CH_PAREN_OPEN)  ||
                      (in_byte == bcs_pkg::CH_PAREN_CLOSE) ||
                      (in_byte == bcs_pkg::CH_BRACE_OPEN)  ||
                      (in_byte == bcs_pkg::CH_BRACE_CLOSE) ||
                      (in_byte == bcs_pkg::CH_SQUARE_OPEN) ||
                      (in_byte == bcs_pkg::CH_SQUARE_CLOSE) ||
                      (in_byte == bcs_pkg::CH_ANGLE_OPEN)  ||
                      (in_byte == bcs_pkg::CH_ANGLE_CLOSE);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kept) && $stable(out_byte) &&
                                   $stable(end_of_string)))
    else $error("result changed while stalled");

  // every accepted request shows its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (out_valid && (end_of_string == $past(last_of_string))))
    else $error("result missing or end flag wrong");

  // brackets never pass
  a_bracket_dropped: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_bracket) |=> !kept)
    else $error("bracket byte kept");

  // a kept byte is the request byte, a dropped one reads zero
  a_byte_value: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (kept ? (out_byte == $past(in_byte)) : (out_byte == 8'h00)))
    else $error("out_byte does not match");

endmodule

bind bracket_content_stripper bcs_checker u_bcs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_byte        (in_byte),
  .last_of_string (last_of_string),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .kept           (kept),
  .out_byte       (out_byte),
  .end_of_string  (end_of_string)
);

>>> verif/tb.sv
// self-checking testbench for the bracket content stripper
`timescale 1ns / 1ps

module tb;

  // depth counter kept narrow so that saturation is reachable with short strings
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DEPTH_BITS  = 5;
  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = '1;
  localparam logic [bcs_pkg::PADDR_W-1:0] NEST_LIMIT_ADDR =
    bcs_pkg::PADDR_W'(4 * int'(bcs_pkg::REG_NEST_LIMIT));
  localparam int unsigned PHASE_ITEMS = 65;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // config port
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [bcs_pkg::PADDR_W-1:0] paddr   = '0;
  logic [bcs_pkg::PDATA_W-1:0] pwdata  = '0;
  logic [bcs_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  // byte requests and filtered results
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte        = 8'h00;
  logic       last_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic       kept;
  logic [7:0] out_byte;
  logic       end_of_string;

  // text waiting to be sent, and filter results still owed by the block
  text_item_t       text_q[$];
  bcs_pkg::result_t filtered_q[$];
  int unsigned queued_total = 0;
  int unsigned accepted     = 0;
  int unsigned errors       = 0;

  // random gaps and stalls on; cleared for the closing phase
  bit idling_on = 1'b1;
  // long output hold-off: bumped by the sequencer, served by the receiver
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;

  // shadow of the filter state
  bcs_pkg::kind_t        shadow_kinds[STACK_DEPTH];
  logic [DEPTH_BITS-1:0] shadow_depth = '0;
  logic [4:0]            shadow_limit = bcs_pkg::NEST_LIMIT_RESET;

  bracket_content_stripper #(
    .STACK_DEPTH(STACK_DEPTH),
    .DEPTH_COUNT_BITS(DEPTH_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .last_of_string(last_of_string),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kept(kept),
    .out_byte(out_byte),
    .end_of_string(end_of_string)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the shadow filter by one byte and return what the block must emit
  function automatic bcs_pkg::result_t strip_byte(input logic [7:0] ch, input logic last);
    bcs_pkg::result_t r;
    bcs_pkg::kind_t   k;
    bcs_pkg::bclass_t c;
    int unsigned      lim;
    // limit beyond the stack is clipped to the stack size
    lim = (shadow_limit < STACK_DEPTH) ? shadow_limit : STACK_DEPTH;
    case (ch)
      bcs_pkg::CH_PAREN_OPEN, bcs_pkg::CH_PAREN_CLOSE:   k = bcs_pkg::KIND_PAREN;
      bcs_pkg::CH_BRACE_OPEN, bcs_pkg::CH_BRACE_CLOSE:   k = bcs_pkg::KIND_BRACE;
      bcs_pkg::CH_SQUARE_OPEN, bcs_pkg::CH_SQUARE_CLOSE: k = bcs_pkg::KIND_SQUARE;
      default:                                           k = bcs_pkg::KIND_ANGLE;
    endcase
    case (ch)
      bcs_pkg::CH_PAREN_OPEN, bcs_pkg::CH_BRACE_OPEN,
      bcs_pkg::CH_SQUARE_OPEN, bcs_pkg::CH_ANGLE_OPEN:   c = bcs_pkg::CLS_OPEN;
      bcs_pkg::CH_PAREN_CLOSE, bcs_pkg::CH_BRACE_CLOSE,
      bcs_pkg::CH_SQUARE_CLOSE, bcs_pkg::CH_ANGLE_CLOSE: c = bcs_pkg::CLS_CLOSE;
      default:                                           c = bcs_pkg::CLS_OTHER;
    endcase
    r.kept          = 1'b0;
    r.out_byte      = 8'h00;
    r.end_of_string = last;
    case (c)
      bcs_pkg::CLS_OPEN: begin
        if (shadow_depth < lim) shadow_kinds[shadow_depth] = k;
        // counter saturates, the bracket is still dropped
        if (shadow_depth != DEPTH_FULL) shadow_depth = shadow_depth + 1'b1;
      end
      bcs_pkg::CLS_CLOSE: begin
        if (shadow_depth > lim) begin
          shadow_depth = shadow_depth - 1'b1;
        end else if (shadow_depth != 0 && shadow_kinds[shadow_depth - 1'b1] == k) begin
          shadow_depth = shadow_depth - 1'b1;
        end
      end
      default: begin
        if (shadow_depth == 0) begin
          r.kept     = 1'b1;
          r.out_byte = ch;
        end
      end
    endcase
    if (last) shadow_depth = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------------
  function automatic void add_char(input logic [7:0] ch, input logic last);
    text_item_t it;
    it.ch   = ch;
    it.last = last;
    text_q.push_back(it);
    queued_total++;
  endfunction

  function automatic logic [7:0] open_of(input bcs_pkg::kind_t k);
    case (k)
      bcs_pkg::KIND_PAREN:  return bcs_pkg::CH_PAREN_OPEN;
      bcs_pkg::KIND_BRACE:  return bcs_pkg::CH_BRACE_OPEN;
      bcs_pkg::KIND_SQUARE: return bcs_pkg::CH_SQUARE_OPEN;
      default:              return bcs_pkg::CH_ANGLE_OPEN;
    endcase
  endfunction

  function automatic logic [7:0] close_of(input bcs_pkg::kind_t k);
    case (k)
      bcs_pkg::KIND_PAREN:  return bcs_pkg::CH_PAREN_CLOSE;
      bcs_pkg::KIND_BRACE:  return bcs_pkg::CH_BRACE_CLOSE;
      bcs_pkg::KIND_SQUARE: return bcs_pkg::CH_SQUARE_CLOSE;
      default:              return bcs_pkg::CH_ANGLE_CLOSE;
    endcase
  endfunction

  // mostly lower-case letters, sometimes any byte at all
  function automatic logic [7:0] filler();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // mostly well-nested text; deep strings open far past the limit and the counter
  function automatic void add_string(input int unsigned span, input bit deep);
    bcs_pkg::kind_t open_kinds[$];
    bcs_pkg::kind_t k;
    int unsigned    r;
    if (deep) begin
      repeat ($urandom_range(18, 40)) begin
        k = bcs_pkg::kind_t'($urandom_range(0, 3));
        open_kinds.push_back(k);
        add_char(open_of(k), 1'b0);
        if ($urandom_range(0, 3) == 0) add_char(filler(), 1'b0);
      end
    end
    repeat (span) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        k = bcs_pkg::kind_t'($urandom_range(0, 3));
        open_kinds.push_back(k);
        add_char(open_of(k), 1'b0);
      end else if (r < 45 && open_kinds.size() > 0) begin
        add_char(close_of(open_kinds.pop_back()), 1'b0);
      end else if (r < 52) begin
        // stray close: may mismatch or come at depth zero
        add_char(close_of(bcs_pkg::kind_t'($urandom_range(0, 3))), 1'b0);
      end else begin
        add_char(filler(), 1'b0);
      end
    end
    // usually unwind, sometimes leave brackets open for the end marker to clear
    while (open_kinds.size() > 0 && $urandom_range(0, 7) != 0)
      add_char(close_of(open_kinds.pop_back()), 1'b0);
    if ($urandom_range(0, 3) == 0)
      add_char(close_of(bcs_pkg::kind_t'($urandom_range(0, 3))), 1'b1);
    else add_char(filler(), 1'b1);
  endfunction

  // raw bytes with random end markers; always closed by an end marker
  function automatic void add_noise(input int unsigned span);
    repeat (span) add_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    add_char(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // config port: write nest_limit, then read it back
  // ---------------------------------------------------------------------------
  task automatic set_nest_limit(input logic [4:0] value);
    logic [bcs_pkg::PDATA_W-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NEST_LIMIT_ADDR;
    pwdata  <= bcs_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    shadow_limit = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== bcs_pkg::PDATA_W'(value)) begin
      $display("%0t: nest_limit readback expected %0d actual %0d", $time, value, readback);
      errors++;
    end
  endtask

  // every request taken and every result seen, then a few quiet cycles
  task automatic wait_drained();
    while (accepted != queued_total || filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers queued bytes, holds each until taken, random gap bursts
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    text_item_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // a request taken at this edge: predict its result now
      if (in_valid && in_ready) begin
        filtered_q.push_back(strip_byte(in_byte, last_of_string));
        accepted++;
      end
      // a pending request stays put with its payload until taken
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idling_on && text_q.size() > 0 && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          cur = text_q.pop_front();
          in_valid       <= 1'b1;
          in_byte        <= cur.ch;
          last_of_string <= cur.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      stall_left = 63;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bcs_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: result with nothing expected, kept %0b byte %02h end %0b",
                 $time, kept, out_byte, end_of_string);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (kept !== want.kept) begin
          $display("%0t: kept expected %0b actual %0b", $time, want.kept, kept);
          errors++;
        end
        if (out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, out_byte);
          errors++;
        end
        if (end_of_string !== want.end_of_string) begin
          $display("%0t: end_of_string expected %0b actual %0b",
                   $time, want.end_of_string, end_of_string);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [4:0]  limits[8];
    int unsigned phase_start;
    limits = '{5'd0, 5'd1, 5'd3, 5'd16, 5'd31, 5'd2, 5'd17, 5'd7};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed text under the reset limit
    add_char(8'h00, 1'b0);                        // lowest byte kept
    add_char(8'hFF, 1'b0);                        // highest byte kept
    add_char(bcs_pkg::CH_PAREN_CLOSE, 1'b0);      // close at depth zero is ignored
    add_char(bcs_pkg::CH_PAREN_OPEN, 1'b0);
    add_char("x", 1'b0);                          // nested text dropped
    add_char(bcs_pkg::CH_PAREN_CLOSE, 1'b0);
    add_char("y", 1'b0);                          // kept again after the pop
    add_char(bcs_pkg::CH_BRACE_OPEN, 1'b0);
    add_char(bcs_pkg::CH_SQUARE_CLOSE, 1'b0);     // wrong kind, no pop
    add_char("z", 1'b0);                          // still nested
    add_char(bcs_pkg::CH_BRACE_CLOSE, 1'b0);
    add_char("k", 1'b0);
    add_char(bcs_pkg::CH_SQUARE_OPEN, 1'b0);
    add_char(bcs_pkg::CH_ANGLE_OPEN, 1'b0);
    add_char(bcs_pkg::CH_ANGLE_CLOSE, 1'b0);
    add_char(bcs_pkg::CH_SQUARE_CLOSE, 1'b1);     // end marker on a bracket
    add_char(bcs_pkg::CH_ANGLE_OPEN, 1'b0);
    add_char("q", 1'b1);                          // string ends while nested
    add_char("w", 1'b1);                          // depth cleared, kept, end on text
    wait_drained();

    // random phases, one limit each; limit only changes between whole strings
    foreach (limits[i]) begin
      if (i == $size(limits) - 1) idling_on = 1'b0;
      set_nest_limit(limits[i]);
      phase_start = queued_total;
      while (queued_total - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) add_noise($urandom_range(2, 20));
        else add_string($urandom_range(3, 30), $urandom_range(0, 4) == 0);
      end
      // block backs up while the sender keeps offering
      if (i == 2) hold_requests++;
      wait_drained();
    end

    if (errors == 0) begin
      $display("[bracket_content_stripper] OK");
    end else begin
      $display("[bracket_content_stripper] ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2_500_000;
    $display("[bracket_content_stripper] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bcs_pkg.sv
rtl/bcs_ram.sv
rtl/bcs_regs.sv
rtl/bcs_core.sv
rtl/bracket_content_stripper.sv
rtl/bcs_checker.sv
verif/tb.sv
